>>> rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// types and constants shared by the sha-256 byte stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428A2F98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF; 6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B; 6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4; 6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98; 6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6A09E667; 3'd1: h = 32'hBB67AE85;
            3'd2: h = 32'h3C6EF372; 3'd3: h = 32'hA54FF53A;
            3'd4: h = 32'h510E527F; 3'd5: h = 32'h9B05688C;
            3'd6: h = 32'h1F83D9AB; 3'd7: h = 32'h5BE0CD19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

endpackage

>>> rtl/sha_byte_if.sv
// ----------------------------------------------------------------------------
// sha_byte_if
// input channel: one action and one message byte per word
// ----------------------------------------------------------------------------
interface sha_byte_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, action, data_byte, input ready);
    modport sink   (input valid, action, data_byte, output ready);
endinterface

>>> rtl/sha_digest_if.sv
// ----------------------------------------------------------------------------
// sha_digest_if
// output channel: one digest word per handshake
// ----------------------------------------------------------------------------
interface sha_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        word_last;

    modport source (output valid, digest_word, word_last, input ready);
    modport sink   (input valid, digest_word, word_last, output ready);
endinterface

>>> rtl/sha_ram.sv
// ----------------------------------------------------------------------------
// sha_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 over a byte stream, digest out as eight 32-bit words
// ----------------------------------------------------------------------------
// The 64th byte of a block starts a compression that holds ready low while it
// reads the byte ram into the message schedule (one byte per cycle), runs the
// 64 rounds at one per cycle, and adds the working state back into the hash ram
// (each word is read, then written back with the sum in the next cycle). A
// finish word writes the 0x80 byte, then the remaining pad bytes one per cycle
// up to byte 63 (a finish with 63 bytes waiting goes straight to the
// compression), runs one compression, or two when 56 or more bytes were waiting
// (the length block takes a second pass over the pad bytes), then hands out
// eight digest words, H0 first, each read from the hash ram; a receiver that
// holds off stalls the output. Message bytes and hash words live in two
// single-port rams; after the digest goes out a flag makes hash ram reads return
// the initial values until the next compression writes them back.
module sha256_byte_stream_hasher (
    input  logic clk,
    input  logic rst_n,
    sha_byte_if.sink     in_ch,
    sha_digest_if.source out_ch
);
    sha_pkg::state_t state_reg, state_next;

    logic [6:0]  idx_reg, idx_next;       // bytes in buffer / step counter
    logic [63:0] bits_reg, bits_next;
    logic [63:0] total_reg, total_next;
    logic        fin_reg, fin_next;       // compression belongs to finish
    logic        second_reg, second_next; // a length block must follow
    logic        hinit_reg, hinit_next;   // hash ram holds stale data: use iv
    logic [31:0] s_reg [8];
    logic [31:0] s_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] dw_reg, dw_next;
    logic        ov_reg, ov_next;
    logic        ol_reg, ol_next;

    logic        b_we;
    logic [5:0]  b_addr;
    logic [7:0]  b_wdata, b_rdata;
    logic        h_we;
    logic [2:0]  h_addr;
    logic [31:0] h_wdata, h_rdata, h_val;

    sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
    );
    sha_ram #(.WIDTH(32), .DEPTH(8)) u_hash (
        .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_val)
    );

    logic [2:0] hsel_reg;
    always_ff @(posedge clk)
    begin
        hsel_reg <= h_addr;
    end
    assign h_rdata = hinit_reg ? sha_pkg::init_h(hsel_reg) : h_val;

    // round datapath
    logic [31:0] sg0, sg1, wnew, big0, big1, ch, maj, t1, t2, wcur;
    always_comb
    begin
        sg0  = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
             ^ (w_reg[1] >> 3);
        sg1  = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
             ^ (w_reg[14] >> 10);
        wnew = sg1 + w_reg[9] + sg0 + w_reg[0];
        wcur = w_reg[0];
        big1 = {s_reg[4][5:0], s_reg[4][31:6]} ^ {s_reg[4][10:0], s_reg[4][31:11]}
             ^ {s_reg[4][24:0], s_reg[4][31:25]};
        ch   = (s_reg[4] & s_reg[5]) ^ (~s_reg[4] & s_reg[6]);
        big0 = {s_reg[0][1:0], s_reg[0][31:2]} ^ {s_reg[0][12:0], s_reg[0][31:13]}
             ^ {s_reg[0][21:0], s_reg[0][31:22]};
        maj  = (s_reg[0] & s_reg[1]) ^ (s_reg[0] & s_reg[2]) ^ (s_reg[1] & s_reg[2]);
        t1   = s_reg[7] + big1 + ch + sha_pkg::round_k(idx_reg[5:0]) + wcur;
        t2   = big0 + maj;
    end

    assign in_ch.ready        = (state_reg == sha_pkg::ST_IDLE);
    assign out_ch.valid       = ov_reg;
    assign out_ch.digest_word = dw_reg;
    assign out_ch.word_last   = ol_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.action)
                        state_next = (idx_reg == 7'd63) ? sha_pkg::ST_LOAD
                                                        : sha_pkg::ST_PAD;
                    else if (idx_reg == 7'd63)
                        state_next = sha_pkg::ST_LOAD;
                end
            end
            sha_pkg::ST_PAD:
            begin
                if (idx_reg == 7'd63)
                    state_next = sha_pkg::ST_LOAD;
            end
            sha_pkg::ST_LOAD:
            begin
                if (idx_reg == 7'd64)
                    state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND:
            begin
                if (idx_reg == 7'd63)
                    state_next = sha_pkg::ST_ADD;
            end
            sha_pkg::ST_ADD:
            begin
                if (idx_reg == 7'd15)
                begin
                    if (!fin_reg)
                        state_next = sha_pkg::ST_IDLE;
                    else if (second_reg)
                        state_next = sha_pkg::ST_PAD;
                    else
                        state_next = sha_pkg::ST_EMIT;
                end
            end
            sha_pkg::ST_EMIT:
            begin
                if (idx_reg == 7'd9 && (!ov_reg || out_ch.ready))
                    state_next = sha_pkg::ST_IDLE;
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        idx_next    = idx_reg;
        bits_next   = bits_reg;
        total_next  = total_reg;
        fin_next    = fin_reg;
        second_next = second_reg;
        hinit_next  = hinit_reg;
        dw_next     = dw_reg;
        ov_next     = ov_reg;
        ol_next     = ol_reg;
        for (int i = 0; i < 8; i++)
            s_next[i] = s_reg[i];
        for (int i = 0; i < 16; i++)
            w_next[i] = w_reg[i];
        b_we    = 1'b0;
        b_addr  = idx_reg[5:0];
        b_wdata = in_ch.data_byte;
        h_we    = 1'b0;
        h_addr  = 3'd0;
        h_wdata = 32'h0;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.action)
                    begin
                        b_we        = 1'b1;
                        b_wdata     = sha_pkg::PAD_BYTE;
                        total_next  = bits_reg + {55'd0, idx_reg[5:0], 3'd0};
                        second_next = (idx_reg[5:0] >= sha_pkg::LEN_POS);
                        fin_next    = 1'b1;
                        // pad byte fills the block: compress right away
                        if (idx_reg == 7'd63)
                            idx_next = 7'd0;
                        else
                            idx_next = {1'b0, idx_reg[5:0]} + 7'd1;
                    end
                    else
                    begin
                        b_we     = 1'b1;
                        fin_next = 1'b0;
                        if (idx_reg == 7'd63)
                        begin
                            idx_next  = 7'd0;
                            bits_next = bits_reg + 64'd512;
                        end
                        else
                            idx_next = idx_reg + 7'd1;
                    end
                end
            end
            sha_pkg::ST_PAD:
            begin
                b_we = 1'b1;
                if (idx_reg[5:0] >= sha_pkg::LEN_POS && !second_reg)
                    b_wdata = total_reg[8*(63-idx_reg[5:0]) +: 8];
                else
                    b_wdata = 8'h00;
                if (idx_reg == 7'd63)
                    idx_next = 7'd0;
                else
                    idx_next = idx_reg + 7'd1;
            end
            sha_pkg::ST_LOAD:
            begin
                // byte i read at step i, lands after the registered ram read
                b_addr = idx_reg[5:0];
                h_addr = idx_reg[2:0];
                if (idx_reg != 7'd0)
                begin
                    for (int i = 0; i < 15; i++)
                        w_next[i] = w_reg[i + 1];
                    w_next[15] = {w_reg[15][23:0], b_rdata};
                    if (idx_reg[1:0] != 2'd1)
                        w_next[15] = w_reg[15];
                end
                // pack bytes: shift in a fresh word on each group of four
                if (idx_reg != 7'd0)
                begin
                    if (idx_reg[1:0] == 2'd1)
                    begin
                        for (int i = 0; i < 15; i++)
                            w_next[i] = w_reg[i + 1];
                        w_next[15] = {24'd0, b_rdata};
                    end
                    else
                    begin
                        for (int i = 0; i < 15; i++)
                            w_next[i] = w_reg[i];
                        w_next[15] = {w_reg[15][23:0], b_rdata};
                    end
                end
                if (idx_reg >= 7'd1 && idx_reg <= 7'd8)
                    s_next[idx_reg[2:0] - 3'd1] = h_rdata;
                if (idx_reg == 7'd64)
                    idx_next = 7'd0;
                else
                    idx_next = idx_reg + 7'd1;
            end
            sha_pkg::ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    w_next[i] = w_reg[i + 1];
                w_next[15] = wnew;
                s_next[7] = s_reg[6];
                s_next[6] = s_reg[5];
                s_next[5] = s_reg[4];
                s_next[4] = s_reg[3] + t1;
                s_next[3] = s_reg[2];
                s_next[2] = s_reg[1];
                s_next[1] = s_reg[0];
                s_next[0] = t1 + t2;
                idx_next  = (idx_reg == 7'd63) ? 7'd0 : idx_reg + 7'd1;
            end
            sha_pkg::ST_ADD:
            begin
                // even step reads word i, odd step writes it back with the sum
                h_addr = idx_reg[3:1];
                if (idx_reg[0])
                begin
                    h_we    = 1'b1;
                    h_wdata = h_rdata + s_reg[idx_reg[3:1]];
                end
                if (idx_reg == 7'd15)
                begin
                    hinit_next = 1'b0;
                    idx_next   = 7'd0;
                    if (fin_reg && second_reg)
                        second_next = 1'b0;
                end
                else
                    idx_next = idx_reg + 7'd1;
            end
            sha_pkg::ST_EMIT:
            begin
                // read word i, load it into dw_reg when the output is free
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next = 1'b0;
                    if (idx_reg != 7'd0 && idx_reg != 7'd9)
                    begin
                        ov_next = 1'b1;
                        dw_next = h_rdata;
                        ol_next = (idx_reg == 7'd8);
                    end
                    if (idx_reg == 7'd9)
                    begin
                        idx_next   = 7'd0;
                        bits_next  = 64'd0;
                        hinit_next = 1'b1;
                        fin_next   = 1'b0;
                    end
                    else
                        idx_next = idx_reg + 7'd1;
                    h_addr = idx_reg[2:0];
                end
                else
                    h_addr = idx_reg[2:0] - 3'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha_pkg::ST_IDLE;
            idx_reg    <= 7'd0;
            bits_reg   <= 64'd0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            hinit_reg  <= 1'b1;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            bits_reg   <= bits_next;
            fin_reg    <= fin_next;
            second_reg <= second_next;
            hinit_reg  <= hinit_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        dw_reg    <= dw_next;
        ol_reg    <= ol_next;
        for (int i = 0; i < 8; i++)
            s_reg[i] <= s_next[i];
        for (int i = 0; i < 16; i++)
            w_reg[i] <= w_next[i];
    end
endmodule

>>> bench/tb_channels.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_channels
// bench-side helpers shared by the hasher tests: opcode names for the input word
// ----------------------------------------------------------------------------
package tb_sha_defs;
    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;
endpackage

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the sha-256 byte stream hasher against a behavioral digest predictor;
// directed messages around the pad boundaries and under receiver hold-off, then
// random messages at several rates of sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } digest_t;

    logic clk;
    logic rst_n;

    sha_byte_if   in_ch ();
    sha_digest_if out_ch ();

    sha256_byte_stream_hasher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // predictor state
    logic [31:0] hash_h [8];
    logic [7:0]  msg_buf [64];
    int          msg_fill;
    logic [63:0] done_bits;

    digest_t     digest_q [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    int          errors;
    int          quiet_cycles;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    function automatic logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                    hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + SHA_K[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endtask

    task automatic clear_hash();
        foreach (hash_h[i]) hash_h[i] = SHA_IV[i];
        msg_fill  = 0;
        done_bits = '0;
    endtask

    task automatic predict_digest(logic act, logic [7:0] b);
        logic [63:0] total;
        int          idx;
        digest_t     d;
        if (act == tb_sha_defs::ACT_ABSORB)
        begin
            msg_buf[msg_fill] = b;
            msg_fill++;
            if (msg_fill == 64)
            begin
                compress_block();
                done_bits += 64'd512;
                msg_fill = 0;
            end
            return;
        end
        total = done_bits + 64'(msg_fill * 8);
        idx = msg_fill;
        msg_buf[idx] = 8'h80;
        idx++;
        // tail too long for the length field: extra block
        if (idx > 56)
        begin
            while (idx < 64) begin msg_buf[idx] = 8'h00; idx++; end
            compress_block();
            idx = 0;
        end
        while (idx < 56) begin msg_buf[idx] = 8'h00; idx++; end
        for (int i = 0; i < 8; i++)
            msg_buf[63-i] = total[8*i +: 8];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = hash_h[i];
            d.word_last   = (i == 7);
            digest_q.push_back(d);
        end
        clear_hash();
    endtask

    always #1 clk = ~clk;

    // sends one word, with a random gap first
    task automatic send_word(logic act, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict_digest(act, b);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
            send_word(tb_sha_defs::ACT_ABSORB, 8'($urandom));
        send_word(tb_sha_defs::ACT_FINISH, 8'($urandom));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
    endtask

    // receiver stall pattern, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        digest_t d;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (digest_q.size() == 0)
            begin
                $display("%0t: unexpected digest word, expected none, actual %h last %b",
                         $time, out_ch.digest_word, out_ch.word_last);
                errors++;
            end
            else
            begin
                d = digest_q.pop_front();
                if (out_ch.digest_word !== d.digest_word)
                begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, d.digest_word, out_ch.digest_word);
                    errors++;
                end
                if (out_ch.word_last !== d.word_last)
                begin
                    $display("%0t: word_last expected %b actual %b",
                             $time, d.word_last, out_ch.word_last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // empty message, tail that just fits, tail that needs a length block,
    // and a pad byte that fills the block
    task automatic test_boundaries();
        send_message(0);
        send_message(55);
        send_message(56);
        send_message(63);
        wait_drained();
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 400;
        send_message(3);
        send_message(2);
        send_message(5);
        wait_drained();
        // sender pauses until all digests are out
        send_message(1);
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(9))
                0:       len = 0;
                1:       len = $urandom_range(54, 66);
                2:       len = $urandom_range(120, 130);
                default: len = $urandom_range(1, 12);
            endcase
            if (len > n_items - sent - 1)
                len = n_items - sent - 1;
            send_message(len);
            sent += len + 1;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = tb_sha_defs::ACT_ABSORB;
        in_ch.data_byte = 8'h00;
        out_ch.ready = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        hold_off_cycles = 0;
        send_idle_pct = 30;
        recv_stall_pct = 68;
        clear_hash();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (20) @(posedge clk);

        test_boundaries();
        test_back_pressure();
        test_random(14);
        send_idle_pct = 68;
        recv_stall_pct = 30;
        test_random(12);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(12);

        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0 && digest_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
